// ===== rtl/core/tte_pkg.sv =====
// tte_pkg: shared types and constants for the timestamp text to epoch converter.
// Holds the sequencer state type, field layout constants and the day-of-year table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

  localparam int unsigned TsLen      = 14;
  localparam int unsigned PosW       = 4;
  localparam int unsigned AccW       = 14;
  localparam int unsigned EpochW     = 40;
  localparam int unsigned MulBW      = 19;

  localparam logic [7:0] CharZero    = 8'h30;
  localparam logic [7:0] CharNine    = 8'h39;
  localparam logic [7:0] CharMinus   = 8'h2D;

  // field end positions
  localparam logic [PosW-1:0] PosDayEnd   = 4'd1;
  localparam logic [PosW-1:0] PosMonEnd   = 4'd3;
  localparam logic [PosW-1:0] PosYearEnd  = 4'd7;
  localparam logic [PosW-1:0] PosHourEnd  = 4'd9;
  localparam logic [PosW-1:0] PosMinEnd   = 4'd11;

  localparam logic signed [MulBW-1:0] RecipEra   = 19'sd5243;   // 2^21/400, rounded up
  localparam int unsigned             RecipShift = 21;
  localparam logic signed [MulBW-1:0] NegEraLen  = -19'sd400;
  localparam logic signed [MulBW-1:0] DaysYear   = 19'sd365;
  localparam logic signed [MulBW-1:0] DaysEra    = 19'sd146097;
  localparam logic signed [MulBW-1:0] HoursDay   = 19'sd24;
  localparam logic signed [MulBW-1:0] SixtyMul   = 19'sd60;
  localparam logic signed [EpochW-1:0] EpochShift = 40'sd719468;
  localparam logic signed [16:0]      EraBias    = 17'sd399;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERA,
    ST_YOE,
    ST_DOE,
    ST_DAYS,
    ST_HOUR,
    ST_MIN,
    ST_SEC,
    ST_DONE
  } state_e;

  // days from March 1 to the first of the month
  function automatic logic [8:0] month_base(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd306;
      4'd2:    r = 9'd337;
      4'd3:    r = 9'd0;
      4'd4:    r = 9'd31;
      4'd5:    r = 9'd61;
      4'd6:    r = 9'd92;
      4'd7:    r = 9'd122;
      4'd8:    r = 9'd153;
      4'd9:    r = 9'd184;
      4'd10:   r = 9'd214;
      4'd11:   r = 9'd245;
      4'd12:   r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/timestamp_text_to_epoch.sv =====
// Timestamp text to epoch converter top level.
// Parses DDMMYYYYHHMMSS text and runs a shared multiply-add sequencer; uses tte_pkg.
//
// One character beat is taken per cycle while idle. On the beat marked tlast the
// input goes not ready while one shared multiply-add unit (40 x 19 bits, acc = a*b + c)
// steps through seven operations: era by reciprocal, year of era, day of era, days,
// hours, minutes and seconds. The result is then registered once the output register is
// free, and input is ready again from that point. The result beat waits in its own
// register; a new timestamp can stream in while it is pending. Characters past the
// fourteenth are dropped; a short or malformed timestamp, or one with month or day out
// of range, gives tuser low and tdata zero.
`timescale 1ns / 1ps
`default_nettype none

module timestamp_text_to_epoch (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,    // [7:0] char_code
  input  wire         s_axis_tlast_i,    // last_char
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,    // [39:0] epoch_seconds (signed)
  output logic        m_axis_tuser_o     // [0] valid_res
);

  localparam int unsigned PosW   = tte_pkg::PosW;
  localparam int unsigned AccW   = tte_pkg::AccW;
  localparam int unsigned EpochW = tte_pkg::EpochW;
  localparam int unsigned MulBW  = tte_pkg::MulBW;

  tte_pkg::state_e state_q, state_d;

  logic [PosW-1:0]          pos_q, pos_d;
  logic [AccW-1:0]          facc_q, facc_d;
  logic                     fneg_q, fneg_d;
  logic                     err_q, err_d;
  logic signed [7:0]        day_q, mon_q, hour_q, min_q;
  logic signed [14:0]       year_q;
  logic signed [EpochW-1:0] acc_q, acc_d;
  logic signed [5:0]        era_q, era_d;
  logic                     ok_q, ok_d;
  logic                     mv_q;
  logic [EpochW-1:0]        mdata_q;
  logic                     muser_q;

  logic                     s_fire, take, fstart, is_digit, is_minus;
  logic [3:0]               dval;
  logic signed [15:0]       fval, sec_val;
  logic                     ld_out;

  logic signed [14:0]       y_adj;
  logic                     y_neg;
  logic signed [16:0]       era_num;
  logic signed [5:0]        era_mag;
  logic [8:0]               yoe;
  logic [1:0]               yq;
  logic                     ok_now;

  logic signed [EpochW-1:0] mul_a, mul_c;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [EpochW+MulBW-1:0] prod;

  assign s_axis_tready_o = (state_q == tte_pkg::ST_IDLE);
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;
  assign take            = s_fire & (pos_q < PosW'(tte_pkg::TsLen));

  // character parse
  always_comb begin
    is_digit = (s_axis_tdata_i >= tte_pkg::CharZero) && (s_axis_tdata_i <= tte_pkg::CharNine);
    is_minus = (s_axis_tdata_i == tte_pkg::CharMinus);
    dval     = is_digit ? 4'(s_axis_tdata_i - tte_pkg::CharZero) : 4'd0;
    fstart   = (pos_q == 4'd0) || (pos_q == 4'd2) || (pos_q == 4'd4) ||
               (pos_q == 4'd8) || (pos_q == 4'd10) || (pos_q == 4'd12);
    facc_d = facc_q;
    fneg_d = fneg_q;
    err_d  = err_q;
    if (fstart) begin
      fneg_d = is_minus;
      facc_d = is_digit ? AccW'(dval) : '0;
      if (!is_digit && !is_minus) begin
        err_d = 1'b1;
      end
    end else if (is_digit) begin
      facc_d = AccW'(facc_q * 4'd10 + AccW'(dval));
    end else begin
      err_d = 1'b1;
    end
    fval    = fneg_d ? -$signed({2'b00, facc_d}) : $signed({2'b00, facc_d});
    sec_val = fneg_q ? -$signed({2'b00, facc_q}) : $signed({2'b00, facc_q});
  end

  // calendar terms
  always_comb begin
    y_neg   = 1'b0;
    y_adj   = ((mon_q == 8'sd1) || (mon_q == 8'sd2)) ? year_q - 15'sd1 : year_q;
    y_neg   = y_adj[14];
    era_num = y_neg ? (tte_pkg::EraBias - 17'(y_adj)) : 17'(y_adj);
    era_mag = $signed({1'b0, acc_q[tte_pkg::RecipShift +: 5]});
    era_d   = y_neg ? -era_mag : era_mag;
    yoe     = acc_q[8:0];
    yq      = (yoe >= 9'd300) ? 2'd3 : (yoe >= 9'd200) ? 2'd2 : (yoe >= 9'd100) ? 2'd1 : 2'd0;
    ok_now  = (pos_q == PosW'(tte_pkg::TsLen)) && !err_q &&
              (mon_q >= 8'sd1) && (mon_q <= 8'sd12) &&
              (day_q >= 8'sd1) && (day_q <= 8'sd31);
  end

  // sequencer and shared multiply-add operand select
  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    ok_d    = ok_q;
    ld_out  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    mul_c   = '0;
    case (state_q)
      tte_pkg::ST_IDLE: begin
        if (take) begin
          pos_d = pos_q + 4'd1;
        end
        if (s_fire && s_axis_tlast_i) begin
          state_d = tte_pkg::ST_ERA;
        end
      end
      tte_pkg::ST_ERA: begin
        ok_d    = ok_now;
        mul_a   = EpochW'(era_num);
        mul_b   = tte_pkg::RecipEra;
        state_d = tte_pkg::ST_YOE;
      end
      tte_pkg::ST_YOE: begin
        mul_a   = EpochW'(era_d);
        mul_b   = tte_pkg::NegEraLen;
        mul_c   = EpochW'(y_adj);
        state_d = tte_pkg::ST_DOE;
      end
      tte_pkg::ST_DOE: begin
        mul_a   = EpochW'(yoe);
        mul_b   = tte_pkg::DaysYear;
        mul_c   = EpochW'(yoe[8:2]) - EpochW'(yq) + EpochW'(tte_pkg::month_base(mon_q[3:0]))
                  + EpochW'(day_q) - 40'sd1;
        state_d = tte_pkg::ST_DAYS;
      end
      tte_pkg::ST_DAYS: begin
        mul_a   = EpochW'(era_q);
        mul_b   = tte_pkg::DaysEra;
        mul_c   = acc_q - tte_pkg::EpochShift;
        state_d = tte_pkg::ST_HOUR;
      end
      tte_pkg::ST_HOUR: begin
        mul_a   = acc_q;
        mul_b   = tte_pkg::HoursDay;
        mul_c   = EpochW'(hour_q);
        state_d = tte_pkg::ST_MIN;
      end
      tte_pkg::ST_MIN: begin
        mul_a   = acc_q;
        mul_b   = tte_pkg::SixtyMul;
        mul_c   = EpochW'(min_q);
        state_d = tte_pkg::ST_SEC;
      end
      tte_pkg::ST_SEC: begin
        mul_a   = acc_q;
        mul_b   = tte_pkg::SixtyMul;
        mul_c   = EpochW'(sec_val);
        state_d = tte_pkg::ST_DONE;
      end
      tte_pkg::ST_DONE: begin
        if (!mv_q || m_axis_tready_i) begin
          ld_out  = 1'b1;
          pos_d   = '0;
          state_d = tte_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tte_pkg::ST_IDLE;
      end
    endcase
    prod  = mul_a * mul_b;
    acc_d = prod[EpochW-1:0] + mul_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tte_pkg::ST_IDLE;
      pos_q   <= '0;
      err_q   <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      if (take) begin
        err_q <= err_d;
      end else if (ld_out) begin
        err_q <= 1'b0;
      end
      if (ld_out) begin
        mv_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        mv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      facc_q <= facc_d;
      fneg_q <= fneg_d;
      case (pos_q)
        tte_pkg::PosDayEnd:  day_q  <= fval[7:0];
        tte_pkg::PosMonEnd:  mon_q  <= fval[7:0];
        tte_pkg::PosYearEnd: year_q <= fval[14:0];
        tte_pkg::PosHourEnd: hour_q <= fval[7:0];
        tte_pkg::PosMinEnd:  min_q  <= fval[7:0];
        default: begin
        end
      endcase
    end
    if (state_q != tte_pkg::ST_IDLE && state_q != tte_pkg::ST_DONE) begin
      acc_q <= acc_d;
    end
    if (state_q == tte_pkg::ST_YOE) begin
      era_q <= era_d;
    end
    ok_q <= ok_d;
    if (ld_out) begin
      mdata_q <= ok_q ? acc_q : '0;
      muser_q <= ok_q;
    end
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tuser_o  = muser_q;

`ifndef SYNTHESIS
  a_last_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && s_axis_tlast_i) |=> (state_q == tte_pkg::ST_ERA))
    else $error("last beat did not start conversion");

  a_invalid_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("invalid result carries nonzero seconds");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(tte_pkg::TsLen))
    else $error("character position past timestamp length");

  a_load_clears_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_out |=> (pos_q == '0 && !err_q && m_axis_tvalid_o))
    else $error("result load did not reset parser");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb_tte_checker.sv =====
// Passive checker for timestamp_text_to_epoch: watches both stream channels, predicts each
// result beat from the character beats and compares it field by field. Depends on tte_pkg.
`timescale 1ns / 1ps

module tb_tte_checker
  import tte_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,
  input  logic        s_tlast_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,
  input  logic        m_tuser_i,
  output int          errors_o,
  output int          pending_o,
  output int          stamps_o,
  output int          valid_o
);

  typedef struct packed {
    logic signed [EpochW-1:0] secs;
    logic                     ok;
  } epoch_t;

  epoch_t epoch_due_q[$];

  // predictor state
  logic [PosW-1:0]   pos;
  logic [AccW-1:0]   acc;
  logic              neg;
  logic signed [7:0] day_v, mon_v, hr_v, min_v;
  logic signed [14:0] yr_v;
  logic              bad;

  function automatic bit field_start(logic [PosW-1:0] p);
    return p == 0 || p == PosDayEnd + 1 || p == PosMonEnd + 1 || p == PosYearEnd + 1 ||
           p == PosHourEnd + 1 || p == PosMinEnd + 1;
  endfunction

  function automatic longint civil_days(longint y, longint m, longint d);
    longint era, yoe, doy, doe;
    if (m <= 2) y = y - 1;
    era = (y >= 0 ? y : y - 399) / 400;
    yoe = y - era * 400;
    doy = (153 * (m + (m > 2 ? -3 : 9)) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function int field_val();
    return neg ? -int'(acc) : int'(acc);
  endfunction

  task clear_stamp();
    pos = '0;
    acc = '0;
    neg = 1'b0;
    day_v = '0;
    mon_v = '0;
    yr_v = '0;
    hr_v = '0;
    min_v = '0;
    bad = 1'b0;
  endtask

  task absorb_char(logic [7:0] c);
    bit dig;
    int dv;
    dig = c >= CharZero && c <= CharNine;
    dv = dig ? int'(c - CharZero) : 0;
    if (field_start(pos)) begin
      acc = '0;
      neg = 1'b0;
      if (c == CharMinus) neg = 1'b1;
      else if (dig) acc = AccW'(dv);
      else bad = 1'b1;
    end else if (dig) begin
      acc = AccW'(int'(acc) * 10 + dv);
    end else begin
      bad = 1'b1;
    end
    case (pos)
      PosDayEnd:  day_v = 8'(field_val());
      PosMonEnd:  mon_v = 8'(field_val());
      PosYearEnd: yr_v  = 15'(field_val());
      PosHourEnd: hr_v  = 8'(field_val());
      PosMinEnd:  min_v = 8'(field_val());
      default: ;
    endcase
    pos = pos + 1'b1;
  endtask

  function epoch_t predict_epoch();
    epoch_t r;
    longint s;
    r.ok = pos == TsLen && !bad && mon_v >= 1 && mon_v <= 12 && day_v >= 1 && day_v <= 31;
    s = 0;
    if (r.ok)
      s = 60 * (60 * (24 * civil_days(yr_v, mon_v, day_v) + hr_v) + min_v) + field_val();
    r.secs = s[EpochW-1:0];
    return r;
  endfunction

  task report(string what, longint want, longint got);
    errors_o++;
    if (errors_o <= 10)
      $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin
    epoch_t want;
    if (!rst_ni) begin
      clear_stamp();
      epoch_due_q.delete();
      errors_o = 0;
      pending_o = 0;
      stamps_o = 0;
      valid_o = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (epoch_due_q.size() == 0) begin
          report("result beat with nothing outstanding", 0, $signed(m_tdata_i));
        end else begin
          want = epoch_due_q.pop_front();
          if (m_tdata_i !== want.secs)
            report("epoch_seconds", want.secs, $signed(m_tdata_i));
          if (m_tuser_i !== want.ok)
            report("valid_res", want.ok, m_tuser_i);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (pos < TsLen) absorb_char(s_tdata_i);
        if (s_tlast_i) begin
          want = predict_epoch();
          epoch_due_q.push_back(want);
          stamps_o++;
          if (want.ok) valid_o++;
          clear_stamp();
        end
      end
      pending_o = epoch_due_q.size();
    end
  end

endmodule

// ===== tb/sv/tb_timestamp_text_to_epoch.sv =====
// Top testbench for timestamp_text_to_epoch: streams directed and random timestamp text under
// varying idle/stall mixes and one long output hold-off. Uses tte_pkg and tb_tte_checker.
`timescale 1ns / 1ps

module tb_timestamp_text_to_epoch;
  import tte_pkg::*;

  typedef enum int {MIX_NONE, MIX_SEND, MIX_RECV, MIX_BOTH} idle_mix_e;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = '0;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [39:0] m_axis_tdata_o;
  wire         m_axis_tuser_o;

  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   chars_sent = 0;
  int   errs, pending, stamps_seen, valid_seen;
  logic [7:0] txt[$];

  string directed_txt [20] = '{
    "01011970000000", "31121969235959", "29022000123456", "01030000000000",
    "31129999235959", "0101-999000000", "0103-400000000", "15062024-1-0-5",
    "01011970999999", "00011970000000", "32011970000000", "01001970000000",
    "01131970000000", "-1011970000000", "01-11970000000", "0101197a000000",
    "0-011970000000", "0101197000000",  "5",              "010119700000-"
  };

  timestamp_text_to_epoch u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  tb_tte_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_valid),
    .s_tready_i (s_axis_tready_o),
    .s_tdata_i  (s_data),
    .s_tlast_i  (s_last),
    .m_tvalid_i (m_axis_tvalid_o),
    .m_tready_i (m_ready),
    .m_tdata_i  (m_axis_tdata_o),
    .m_tuser_i  (m_axis_tuser_o),
    .errors_o   (errs),
    .pending_o  (pending),
    .stamps_o   (stamps_seen),
    .valid_o    (valid_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // output side; one long hold-off on request
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        m_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_done <= 1'b1;
      end else begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
      @(posedge clk_i);
    end
  end

  task set_mix(idle_mix_e mx);
    case (mx)
      MIX_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      MIX_SEND: begin send_idle_pct = 49; recv_stall_pct = 0;  end
      MIX_RECV: begin send_idle_pct = 0;  recv_stall_pct = 49; end
      MIX_BOTH: begin send_idle_pct = 17; recv_stall_pct = 17; end
      default: ;
    endcase
  endtask

  task send_beat(logic [7:0] c, logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= c;
    s_last  <= l;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    chars_sent++;
  endtask

  task send_txt();
    foreach (txt[i]) send_beat(txt[i], i == txt.size() - 1);
  endtask

  task add_str(string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endtask

  // w characters; a leading minus takes one of them
  task add_field(int v, int w);
    int mag;
    int div;
    mag = v < 0 ? -v : v;
    if (v < 0 || $urandom_range(0, 99) < 4) begin
      txt.push_back(CharMinus);
      w = w - 1;
    end
    div = 1;
    repeat (w - 1) div = div * 10;
    repeat (w) begin
      txt.push_back(8'(CharZero + (mag / div) % 10));
      div = div / 10;
    end
  endtask

  function automatic int pick(int lo, int hi, int wlo, int whi);
    if ($urandom_range(0, 9) == 0) return wlo + int'($urandom_range(0, whi - wlo));
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  task make_random_stamp();
    int kind, n, yr, r;
    txt.delete();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      n = $urandom_range(1, 20);
      repeat (n) txt.push_back(8'($urandom_range(0, 255)));
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40) yr = 1900 + int'($urandom_range(0, 200));
      else if (r < 85) yr = $urandom_range(0, 9999);
      else yr = -int'($urandom_range(1, 999));
      add_field(pick(1, 31, -9, 99), 2);
      add_field(pick(1, 12, -9, 99), 2);
      add_field(yr, 4);
      add_field(pick(0, 23, -9, 99), 2);
      add_field(pick(0, 59, -9, 99), 2);
      add_field(pick(0, 59, -9, 99), 2);
      if (kind < 27) begin
        txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind < 35) begin
        repeat ($urandom_range(1, 13)) void'(txt.pop_back());
      end else if (kind < 42) begin
        repeat ($urandom_range(1, 5)) txt.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_mix(MIX_NONE);

    foreach (directed_txt[i]) begin
      txt.delete();
      add_str(directed_txt[i]);
      send_txt();
    end
    // trailing characters past the fourteenth, including both byte extremes
    txt.delete();
    add_str("01011970000000");
    txt.push_back(8'hFF);
    txt.push_back(8'h00);
    add_str("7");
    send_txt();

    n = 0;
    while (chars_sent < 1250) begin
      set_mix(idle_mix_e'((n / 10) % 4));
      if (n == 45) hold_req <= 1'b1;
      make_random_stamp();
      send_txt();
      n++;
    end
    s_valid <= 1'b0;
    s_last  <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d characters in %0d timestamps; %0d results checked, %0d of them valid,",
             chars_sent, n + 21, stamps_seen, valid_seen);
    $display("under idle, send-gap, output-stall and mixed phases plus one long output hold-off.");
    if (errs == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
